// ===== rtl/mewd_pkg.sv =====
`timescale 1ns / 1ps

package mewd_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
    } t_out_item;

    // results caused by one request: up to three data bytes, then an optional end marker
    typedef struct packed {
        logic [1:0]      n_data;
        logic [2:0][7:0] data;
        logic            marker;
    } t_bundle;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

// ===== rtl/mime_encoded_word_decoder_unit.sv =====
// MIME encoded word decoder: header text in, decoded bytes out.
// input channel: i_in_valid / o_in_stall carry one text byte and an end flag
// per request; output channel: o_out_valid / i_out_stall carry one result
// (decoded byte, byte_valid, last) per request.
// a front stage decodes each accepted byte in the cycle it arrives and
// queues the one to three results it causes as one entry of a four-entry
// queue (a byte with no result queues nothing); a back stage plays queued
// results out one per cycle from an output register while not stalled.
// throughput: one input request per cycle while the queue has room; the
// output side moves one result per cycle while the output is not stalled.
// the first result of a request is written to the queue, then loaded
// into the output register, where it appears.
// end of text flushes pending escape and base64 bits, emits a marker with
// last set and returns to the reset state.
// reset: synchronous active low, clears decoder state, queue and output.
// a stall on the output holds the current result; once the queue is full
// the input is stalled until the back stage takes an entry.
`timescale 1ns / 1ps

module mime_encoded_word_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mewd_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output mewd_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import mewd_pkg::*;

    t_queue_status qstat;
    t_bundle       push_data;
    t_bundle       head;
    logic          push;
    logic          pop;

    mewd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .o_stall  (o_in_stall),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_bundle (push_data)
    );

    mewd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_qstat     (qstat)
    );

    mewd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

// ===== rtl/mewd_front.sv =====
`timescale 1ns / 1ps

module mewd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  mewd_pkg::t_in_item      i_data,
    output logic                    o_stall,
    input  mewd_pkg::t_queue_status i_qstat,
    output logic                    o_push,
    output mewd_pkg::t_bundle       o_bundle
);
    import mewd_pkg::*;

    localparam logic [2:0] PH_PLAIN   = 3'd0;
    localparam logic [2:0] PH_EQ      = 3'd1;
    localparam logic [2:0] PH_CHARSET = 3'd2;
    localparam logic [2:0] PH_ENC     = 3'd3;
    localparam logic [2:0] PH_TEXT    = 3'd4;
    localparam logic [2:0] PH_TEXT2   = 3'd5;
    localparam logic [2:0] PH_CLOSE   = 3'd6;

    localparam logic [7:0] C_EQ = 8'h3D;
    localparam logic [7:0] C_QM = 8'h3F;
    localparam logic [7:0] C_US = 8'h5F;
    localparam logic [7:0] C_SP = 8'h20;

    typedef struct packed {
        logic [2:0]  phase;
        logic        qmode;
        logic        bmode;
        logic [17:0] acc;
        logic [1:0]  bcnt;
        logic [7:0]  la_byte;
        logic [1:0]  la_cnt;
    } t_fstate;

    typedef struct packed {
        t_fstate st;
        t_bundle b;
    } t_fres;

    t_fstate r_st;
    t_fstate n_st;
    t_bundle bundle;
    logic    accept;

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (c <= 8'h39) begin
            t = c - 8'h30;
        end else begin
            t = c - 8'h37;
        end
        return t[3:0];
    endfunction

    function automatic logic b64_ok(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
            || (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F;
    endfunction

    function automatic logic [5:0] b64_val(input logic [7:0] c);
        logic [7:0] t;
        priority if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'h47;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c + 8'h04;
        end else if (c == 8'h2B) begin
            t = 8'd62;
        end else begin
            t = 8'd63;
        end
        return t[5:0];
    endfunction

    function automatic t_bundle put(input t_bundle b, input logic [7:0] v);
        t_bundle q;
        q = b;
        q.data[q.n_data] = v;
        q.n_data = q.n_data + 2'd1;
        return q;
    endfunction

    function automatic t_fres b64_flush(input t_fres r);
        t_fres q;
        q = r;
        if (q.st.bcnt == 2'd3) begin
            q.b = put(q.b, q.st.acc[17:10]);
            q.b = put(q.b, q.st.acc[9:2]);
        end else if (q.st.bcnt == 2'd2) begin
            q.b = put(q.b, q.st.acc[11:4]);
        end
        q.st.acc   = '0;
        q.st.bcnt  = '0;
        q.st.bmode = 1'b0;
        return q;
    endfunction

    function automatic t_fres b64_add(input t_fres r, input logic [5:0] v);
        t_fres       q;
        logic [23:0] full;
        q    = r;
        full = {q.st.acc, v};
        if (q.st.bcnt == 2'd3) begin
            q.b = put(q.b, full[23:16]);
            q.b = put(q.b, full[15:8]);
            q.b = put(q.b, full[7:0]);
            q.st.acc  = '0;
            q.st.bcnt = '0;
        end else begin
            q.st.acc  = {q.st.acc[11:0], v};
            q.st.bcnt = q.st.bcnt + 2'd1;
        end
        return q;
    endfunction

    function automatic t_fres feed(input t_fres r, input logic [7:0] c);
        t_fres q;
        q = r;
        if ((q.st.phase == PH_TEXT || q.st.phase == PH_TEXT2) && q.st.bmode) begin
            priority if (c == C_EQ) begin
                q = r;
            end else if (c == C_QM) begin
                if (q.st.phase == PH_TEXT) begin
                    q.st.phase = PH_TEXT2;
                end else begin
                    q = b64_flush(q);
                    q.st.phase = PH_CLOSE;
                end
            end else if (!b64_ok(c)) begin
                q = b64_flush(q);
            end else begin
                q = b64_add(q, b64_val(c));
            end
        end else begin
            unique case (q.st.phase)
                PH_CHARSET: begin
                    if (c == C_QM) begin
                        q.st.phase = PH_ENC;
                    end
                end
                PH_TEXT, PH_TEXT2: begin
                    priority if (c == C_QM) begin
                        q.st.phase = (q.st.phase == PH_TEXT) ? PH_TEXT2 : PH_CLOSE;
                    end else if (c == C_EQ) begin
                        if (q.st.qmode) begin
                            q.st.la_cnt = 2'd1;
                        end
                    end else if (c == C_US && q.st.qmode) begin
                        q.b = put(q.b, C_SP);
                    end else begin
                        q.b = put(q.b, c);
                    end
                end
                default: begin
                    if (c == C_EQ) begin
                        q.st.phase = PH_EQ;
                    end else begin
                        q.b = put(q.b, c);
                    end
                end
            endcase
        end
        return q;
    endfunction

    always_comb begin
        t_fres  r;
        logic [7:0] c;
        c      = i_data.text_byte;
        r.st   = r_st;
        r.b    = '0;
        if (i_data.end_of_text) begin
            priority if (r.st.la_cnt == 2'd2) begin
                r.b = put(r.b, r.st.la_byte);
            end else if (r.st.phase == PH_EQ) begin
                r.b = put(r.b, C_EQ);
            end else if (r.st.phase == PH_CLOSE) begin
                r.b = put(r.b, C_QM);
            end else begin
                r.b = r.b;
            end
            if (r.st.bmode) begin
                r = b64_flush(r);
            end
            r.b.marker = 1'b1;
            r.st       = '0;
        end else begin
            priority if (r.st.la_cnt == 2'd1) begin
                if (hex_ok(c)) begin
                    r.st.la_byte = c;
                    r.st.la_cnt  = 2'd2;
                end else begin
                    r.st.la_cnt = 2'd0;
                    r = feed(r, c);
                end
            end else if (r.st.la_cnt >= 2'd2) begin
                r.st.la_cnt = 2'd0;
                if (hex_ok(c)) begin
                    r.b = put(r.b, {hex_val(r.st.la_byte), hex_val(c)});
                end else begin
                    r = feed(r, r.st.la_byte);
                    r = feed(r, c);
                end
            end else if (r.st.phase == PH_EQ) begin
                if (c == C_QM) begin
                    r.st.phase = PH_CHARSET;
                end else begin
                    r.b        = put(r.b, C_EQ);
                    r.st.phase = PH_PLAIN;
                    r = feed(r, c);
                end
            end else if (r.st.phase == PH_ENC) begin
                r.st.phase = PH_TEXT;
                priority if (c == 8'h51 || c == 8'h71) begin
                    r.st.qmode = 1'b1;
                end else if (c == 8'h42 || c == 8'h62) begin
                    r.st.bmode = 1'b1;
                    r.st.acc   = '0;
                    r.st.bcnt  = '0;
                end else begin
                    r = feed(r, c);
                end
            end else if (r.st.phase == PH_CLOSE) begin
                if (c == C_EQ) begin
                    r.st.phase = PH_PLAIN;
                    r.st.qmode = 1'b0;
                end else begin
                    r.b        = put(r.b, C_QM);
                    r.st.phase = PH_TEXT2;
                    r = feed(r, c);
                end
            end else begin
                r = feed(r, c);
            end
        end
        n_st   = r.st;
        bundle = r.b;
    end

    assign accept   = i_valid && !i_qstat.full;
    assign o_stall  = i_qstat.full;
    assign o_push   = accept && (bundle.n_data != 2'd0 || bundle.marker);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

endmodule

// ===== rtl/mewd_queue.sv =====
`timescale 1ns / 1ps

module mewd_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  mewd_pkg::t_bundle       i_push_data,
    input  logic                    i_pop,
    output mewd_pkg::t_bundle       o_head,
    output mewd_pkg::t_queue_status o_qstat
);
    import mewd_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head        = r_mem[r_rd];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == (PTR_W+1)'(DEPTH));

endmodule

// ===== rtl/mewd_back.sv =====
`timescale 1ns / 1ps

module mewd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mewd_pkg::t_bundle       i_head,
    input  mewd_pkg::t_queue_status i_qstat,
    output logic                    o_pop,
    output logic                    o_valid,
    output mewd_pkg::t_out_item     o_data,
    input  logic                    i_stall
);
    import mewd_pkg::*;

    logic [1:0] r_pos;
    logic       r_out_valid;
    t_out_item  r_out;
    logic [1:0] total;
    logic       load;
    logic       at_end;
    t_out_item  item;

    assign total  = i_head.n_data + {1'b0, i_head.marker};
    assign at_end = (r_pos == total - 2'd1);
    assign load   = !i_qstat.empty && (!r_out_valid || !i_stall);
    assign o_pop  = load && at_end;

    always_comb begin
        if (r_pos < i_head.n_data) begin
            item.out_byte   = i_head.data[r_pos];
            item.byte_valid = 1'b1;
            item.last       = 1'b0;
        end else begin
            item.out_byte   = 8'h00;
            item.byte_valid = 1'b0;
            item.last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pos       <= at_end ? 2'd0 : r_pos + 2'd1;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
